@@ sv/assert_macros.svh @@
// assertion macros shared by the huffman decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/hbd_pkg.sv @@
// shared types and constants of the huffman bitstream decoder
package hbd_pkg;

  localparam int SYM_W       = 8;
  localparam int CFG_W       = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [1:0] {
    KIND_BIT,
    KIND_START,
    KIND_START_EMPTY
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  code_bit;
  } item_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TREE,
    PH_WALK,
    PH_HALT
  } phase_e;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             whole_text;
    logic             tree_error;
  } result_t;

endpackage

@@ sv/huffman_bitstream_decoder.sv @@
// top level of the huffman bitstream decoder (preorder tree header)
//
//  channel   direction  tdata bits (low up)      tuser bits (low up)           tlast
//  s_axis    in         [0] code_bit, rest zero  [0] stream_start              -
//  m_axis    out        [7:0] symbol             [0] whole_text, [1] tree_error last
//  cfg       in         cfg_wdata_i: symbol_count (write on cfg_we_i)
//
//  one code bit per cycle sustained while m_axis does not stall; each bit costs
//  one read of the node table, whose two child fields are read together, so
//  the walk loop closes through that registered read
//  the cycle after the tree is complete is a bubble while the walk reads the root
//  a decoded symbol appears on m_axis the cycle after its last code bit enters
//  the back end; a stalled m_axis holds the result and fills the request queue
//  after reset the decoder idles and ignores bits until a stream start; the
//  node table and slot stack need no clearing pass
module huffman_bitstream_decoder #(
  parameter int MAX_NODES   = 512,
  parameter int STACK_DEPTH = 256,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // length register
  input  logic                      cfg_we_i,
  input  logic [hbd_pkg::CFG_W-1:0] cfg_wdata_i,
  // compressed bit requests
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [0] code_bit, [7:1] zero
  input  logic [0:0]                s_axis_tuser,   // [0] stream_start
  // decoded symbol requests
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [7:0] symbol
  output logic                      m_axis_tlast,
  output logic [1:0]                m_axis_tuser    // [0] whole_text, [1] tree_error
);

  logic                      q_full, q_push, q_valid, q_pop;
  hbd_pkg::item_t            push_item, pop_item;
  logic [hbd_pkg::CFG_W-1:0] symbol_count;
  hbd_pkg::result_t          res;

  // front: length register, accept handshake, marks starts and empty texts
  hbd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .code_bit_i     (s_axis_tdata[0]),
    .stream_start_i (s_axis_tuser[0]),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (push_item),
    .symbol_count_o (symbol_count)
  );

  // short queue so input acceptance does not wait on output stalls until it fills
  hbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  // back: tree rebuild, walk and output register
  hbd_back #(
    .MAX_NODES   (MAX_NODES),
    .STACK_DEPTH (STACK_DEPTH),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (pop_item),
    .q_pop_o        (q_pop),
    .symbol_count_i (symbol_count),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_o          (res)
  );

  assign m_axis_tdata = res.symbol;
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = {res.tree_error, res.whole_text};

endmodule

@@ sv/hbd_queue.sv @@
// two-entry request queue between the decoder front and back
`include "assert_macros.svh"

module hbd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hbd_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output hbd_pkg::item_t pop_item_o
);

  hbd_pkg::item_t entry_q [hbd_pkg::QUEUE_DEPTH];
  logic [hbd_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [hbd_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [hbd_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == hbd_pkg::QCNT_W'(hbd_pkg::QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == hbd_pkg::QPTR_W'(hbd_pkg::QUEUE_DEPTH - 1)) ? '0
               : hbd_pkg::QPTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == hbd_pkg::QPTR_W'(hbd_pkg::QUEUE_DEPTH - 1)) ? '0
               : hbd_pkg::QPTR_W'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      cnt_d = hbd_pkg::QCNT_W'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = hbd_pkg::QCNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  `ASSERT_IMPLY(a_no_push_full, clk_i, rst_ni, push_i, !full_o, "push into full queue")
  `ASSERT_IMPLY(a_no_pop_empty, clk_i, rst_ni, pop_i, valid_o, "pop from empty queue")
  `ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= hbd_pkg::QCNT_W'(hbd_pkg::QUEUE_DEPTH), "queue count beyond depth")

endmodule

@@ sv/hbd_front.sv @@
// input side: length register, accept handshake and request classification
module hbd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hbd_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      code_bit_i,
  input  logic                      stream_start_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output hbd_pkg::item_t            q_item_o,
  output logic [hbd_pkg::CFG_W-1:0] symbol_count_o
);

  logic [hbd_pkg::CFG_W-1:0] symbol_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbol_count_q <= '0;
    end else if (cfg_we_i) begin
      symbol_count_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o     = !q_full_i;
  assign q_push_o       = in_valid_i && !q_full_i;
  assign symbol_count_o = symbol_count_q;

  // an empty text ends the stream on its first bit
  always_comb begin
    q_item_o.code_bit = code_bit_i;
    if (!stream_start_i) begin
      q_item_o.kind = hbd_pkg::KIND_BIT;
    end else if (symbol_count_q == '0) begin
      q_item_o.kind = hbd_pkg::KIND_START_EMPTY;
    end else begin
      q_item_o.kind = hbd_pkg::KIND_START;
    end
  end

endmodule

@@ sv/hbd_back.sv @@
// decode engine: tree rebuild, slot stack, node table walk and result register
`include "assert_macros.svh"

module hbd_back #(
  parameter int MAX_NODES   = 512,
  parameter int STACK_DEPTH = 256,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  hbd_pkg::item_t            q_item_i,
  output logic                      q_pop_o,
  input  logic [hbd_pkg::CFG_W-1:0] symbol_count_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output hbd_pkg::result_t          res_o
);

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int PAY_W  = (IDX_W > hbd_pkg::SYM_W) ? IDX_W : hbd_pkg::SYM_W;
  localparam int FLD_W  = PAY_W + 1;
  localparam int SLOT_W = IDX_W + 1;
  localparam int SIDX_W = $clog2(STACK_DEPTH);
  localparam int SCNT_W = $clog2(STACK_DEPTH + 1);
  localparam int LCNT_W = $clog2(SYMBOL_BITS + 1);
  localparam int SYM_W  = hbd_pkg::SYM_W;
  localparam int CFG_W  = hbd_pkg::CFG_W;

  localparam logic [IDX_W-1:0]  TREE_CAP  = IDX_W'(MAX_NODES - 1);
  localparam logic [SCNT_W-1:0] STACK_LIM = SCNT_W'(STACK_DEPTH - 2);
  localparam logic [LCNT_W-1:0] LEAF_BITS = LCNT_W'(SYMBOL_BITS);

  // node table split by child: each field is a child pointer or, with the
  // leaf flag on top, the child's symbol
  logic [FLD_W-1:0]  fmem0 [MAX_NODES];
  logic [FLD_W-1:0]  fmem1 [MAX_NODES];
  logic [SLOT_W-1:0] smem  [STACK_DEPTH];

  hbd_pkg::phase_e   phase_q, phase_d;
  logic [IDX_W-1:0]  nodes_q, nodes_d;
  logic [SCNT_W-1:0] scnt_q, scnt_d;
  logic [SLOT_W-1:0] top_q, top_d;
  logic              refill_q, refill_d;
  logic [SLOT_W-1:0] srd_q;
  logic [LCNT_W-1:0] lcnt_q, lcnt_d;
  logic [SYM_W-1:0]  lval_q, lval_d;
  logic [SLOT_W-1:0] leaf_slot_q, leaf_slot_d;
  logic [IDX_W-1:0]  walk_q, walk_d;
  logic              primed_q, primed_d;
  logic [CFG_W-1:0]  left_q, left_d;
  logic              out_valid_q, out_valid_d;
  hbd_pkg::result_t  out_q, out_d;
  logic [FLD_W-1:0]  frd0_q, frd1_q;

  logic              take, walk_hold, emit;
  hbd_pkg::result_t  res_new;
  logic              f_we, f_sel;
  logic [IDX_W-1:0]  f_addr, f_raddr;
  logic [FLD_W-1:0]  f_wdata;
  logic              s_we, s_re;
  logic [SIDX_W-1:0] s_waddr, s_raddr;
  logic [SLOT_W-1:0] s_wdata;

  always_comb begin
    hbd_pkg::phase_e   cur_phase;
    logic [IDX_W-1:0]  cur_nodes;
    logic [SCNT_W-1:0] cur_scnt;
    logic [LCNT_W-1:0] cur_lcnt;
    logic [SYM_W-1:0]  cur_lval;
    logic              has_parent;
    logic [SCNT_W-1:0] c1, c1m1;
    logic [IDX_W-1:0]  n;
    logic [FLD_W-1:0]  fld;
    logic [SYM_W-1:0]  sym;

    phase_d     = phase_q;
    nodes_d     = nodes_q;
    scnt_d      = scnt_q;
    lcnt_d      = lcnt_q;
    lval_d      = lval_q;
    leaf_slot_d = leaf_slot_q;
    walk_d      = walk_q;
    left_d      = left_q;
    top_d       = refill_q ? srd_q : top_q;
    refill_d    = 1'b0;
    f_we        = 1'b0;
    f_sel       = 1'b0;
    f_addr      = '0;
    f_wdata     = '0;
    f_raddr     = walk_q;
    s_we        = 1'b0;
    s_waddr     = '0;
    s_wdata     = '0;
    s_re        = 1'b0;
    s_raddr     = '0;
    emit        = 1'b0;
    res_new     = '0;
    cur_phase   = phase_q;
    cur_nodes   = nodes_q;
    cur_scnt    = scnt_q;
    cur_lcnt    = lcnt_q;
    cur_lval    = lval_q;
    has_parent  = 1'b0;
    c1          = '0;
    c1m1        = '0;
    n           = '0;
    fld         = '0;
    sym         = '0;

    // node data for the walk trails the tree's last write by the registered table read
    walk_hold = (phase_q == hbd_pkg::PH_WALK) && !primed_q;
    take      = q_valid_i && (!out_valid_q || res_ready_i) && !walk_hold;

    if (take) begin
      if (q_item_i.kind == hbd_pkg::KIND_START_EMPTY) begin
        phase_d = hbd_pkg::PH_HALT;
      end else begin
        if (q_item_i.kind == hbd_pkg::KIND_START) begin
          cur_phase = hbd_pkg::PH_TREE;
          cur_nodes = '0;
          cur_scnt  = '0;
          cur_lcnt  = '0;
          cur_lval  = '0;
          phase_d   = hbd_pkg::PH_TREE;
          nodes_d   = '0;
          scnt_d    = '0;
          lcnt_d    = '0;
          lval_d    = '0;
          walk_d    = '0;
          left_d    = symbol_count_i;
        end
        unique case (cur_phase)
          hbd_pkg::PH_TREE: begin
            if (cur_lcnt != '0) begin
              // symbol bits of a leaf
              sym    = {cur_lval[SYM_W-2:0], q_item_i.code_bit};
              lval_d = sym;
              lcnt_d = LCNT_W'(cur_lcnt - 1'b1);
              if (cur_lcnt == LCNT_W'(1)) begin
                if (cur_nodes != IDX_W'(1)) begin
                  f_we    = 1'b1;
                  f_sel   = leaf_slot_q[0];
                  f_addr  = leaf_slot_q[SLOT_W-1:1];
                  f_wdata = {1'b1, PAY_W'(sym)};
                end
                if (cur_scnt == '0) begin
                  if (cur_nodes == IDX_W'(1)) begin
                    emit               = 1'b1;
                    res_new.symbol     = sym;
                    res_new.last       = 1'b1;
                    res_new.whole_text = 1'b1;
                    phase_d            = hbd_pkg::PH_HALT;
                  end else begin
                    phase_d = hbd_pkg::PH_WALK;
                    walk_d  = '0;
                  end
                end
              end
            end else if (cur_nodes >= TREE_CAP) begin
              emit               = 1'b1;
              res_new.tree_error = 1'b1;
              phase_d            = hbd_pkg::PH_HALT;
            end else begin
              // new node takes the child slot on top of the stack
              n          = cur_nodes;
              nodes_d    = IDX_W'(cur_nodes + 1'b1);
              has_parent = (n != '0) && (cur_scnt != '0);
              c1         = has_parent ? SCNT_W'(cur_scnt - 1'b1) : cur_scnt;
              c1m1       = SCNT_W'(c1 - 1'b1);
              if (q_item_i.code_bit) begin
                if (c1 > STACK_LIM) begin
                  emit               = 1'b1;
                  res_new.tree_error = 1'b1;
                  phase_d            = hbd_pkg::PH_HALT;
                end else begin
                  if (has_parent) begin
                    f_we    = 1'b1;
                    f_sel   = top_q[0];
                    f_addr  = top_q[SLOT_W-1:1];
                    f_wdata = {1'b0, PAY_W'(n)};
                  end
                  // second child slot goes to memory, first stays on top
                  s_we    = 1'b1;
                  s_waddr = c1[SIDX_W-1:0];
                  s_wdata = {n, 1'b1};
                  top_d   = {n, 1'b0};
                  scnt_d  = SCNT_W'(c1 + 2'd2);
                end
              end else begin
                lcnt_d      = LEAF_BITS;
                lval_d      = '0;
                leaf_slot_d = top_q;
                scnt_d      = c1;
                if (has_parent && (c1 != '0)) begin
                  s_re     = 1'b1;
                  s_raddr  = c1m1[SIDX_W-1:0];
                  refill_d = 1'b1;
                end
              end
            end
          end
          hbd_pkg::PH_WALK: begin
            fld = q_item_i.code_bit ? frd1_q : frd0_q;
            if (fld[PAY_W]) begin
              emit           = 1'b1;
              res_new.symbol = fld[SYM_W-1:0];
              res_new.last   = (left_q == CFG_W'(1));
              left_d         = CFG_W'(left_q - 1'b1);
              walk_d         = '0;
              f_raddr        = '0;
              if (left_q == CFG_W'(1)) begin
                phase_d = hbd_pkg::PH_HALT;
              end
            end else begin
              walk_d  = fld[IDX_W-1:0];
              f_raddr = fld[IDX_W-1:0];
            end
          end
          hbd_pkg::PH_IDLE: begin
          end
          hbd_pkg::PH_HALT: begin
          end
        endcase
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = res_new;
    end else begin
      out_valid_d = out_valid_q && !res_ready_i;
      out_d       = out_q;
    end
    primed_d = (phase_q == hbd_pkg::PH_WALK) && (phase_d == hbd_pkg::PH_WALK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hbd_pkg::PH_IDLE;
      nodes_q     <= '0;
      scnt_q      <= '0;
      refill_q    <= 1'b0;
      lcnt_q      <= '0;
      lval_q      <= '0;
      walk_q      <= '0;
      primed_q    <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      nodes_q     <= nodes_d;
      scnt_q      <= scnt_d;
      refill_q    <= refill_d;
      lcnt_q      <= lcnt_d;
      lval_q      <= lval_d;
      walk_q      <= walk_d;
      primed_q    <= primed_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q       <= top_d;
    leaf_slot_q <= leaf_slot_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (f_we && !f_sel) begin
      fmem0[f_addr] <= f_wdata;
    end
    frd0_q <= fmem0[f_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (f_we && f_sel) begin
      fmem1[f_addr] <= f_wdata;
    end
    frd1_q <= fmem1[f_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      srd_q <= smem[s_raddr];
    end
  end

  assign q_pop_o     = take;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  `ASSERT_ALWAYS(a_stack_bound, clk_i, rst_ni, scnt_q <= SCNT_W'(STACK_DEPTH), "slot stack beyond depth")
  `ASSERT_ALWAYS(a_node_bound, clk_i, rst_ni, nodes_q <= TREE_CAP, "node count beyond table capacity")
  `ASSERT_IMPLY(a_walk_primed, clk_i, rst_ni, take && (phase_q == hbd_pkg::PH_WALK), primed_q, "walk step before node data is ready")
  `ASSERT_IMPLY(a_emit_room, clk_i, rst_ni, emit, !out_valid_q || res_ready_i, "result overwrites a pending result")
  `ASSERT_NEXT(a_halt_on_error, clk_i, rst_ni, emit && res_new.tree_error, phase_q == hbd_pkg::PH_HALT, "decoder runs on after tree error")

endmodule

@@ test/tb_top.sv @@
// self-checking testbench of the huffman bitstream decoder
`timescale 1ns / 1ps

module tb_top;
  import hbd_pkg::*;

  localparam int NODE_CAP    = 512;
  localparam int STACK_CAP   = 256;
  localparam int SYM_BITS    = 8;
  localparam int QUIET_LIMIT = 2000;   // cycles without any accepted request
  localparam int RAND_ITEMS  = 1050;
  localparam int TAIL_FROM   = RAND_ITEMS - 150;
  localparam int SETTLE      = 16;     // cycles for requests still inside the block

  // tracks the decoder state and the symbol requests it must produce
  class symbol_scoreboard;
    logic [31:0] count_reg;
    phase_e      ph;
    logic [18:0] node_tab [NODE_CAP];  // [18] leaf, [17:9] first child, [8:0] second / symbol
    logic [9:0]  slot_stk [STACK_CAP]; // node index and child number
    int unsigned stack_top;
    int unsigned nodes_used;
    int unsigned leaf_left;
    logic [7:0]  leaf_shift;
    logic [8:0]  walk_at;
    logic [31:0] syms_left;
    result_t     expected_syms [$];
    int unsigned fails;

    function new();
      count_reg  = '0;
      ph         = PH_IDLE;
      stack_top  = 0;
      nodes_used = 0;
      leaf_left  = 0;
      leaf_shift = '0;
      walk_at    = '0;
      syms_left  = '0;
      fails      = 0;
    endfunction

    function void set_count(logic [31:0] v);
      count_reg = v;
    endfunction

    function int pending();
      return expected_syms.size();
    endfunction

    function void add_expected(logic [7:0] s, logic l, logic w, logic e);
      result_t r;
      r.symbol     = s;
      r.last       = l;
      r.whole_text = w;
      r.tree_error = e;
      expected_syms.push_back(r);
    endfunction

    function void load_tree_bit(bit b);
      logic [8:0] n;
      logic [9:0] slot;
      if (leaf_left != 0) begin
        leaf_shift = {leaf_shift[6:0], b};
        leaf_left--;
        if (leaf_left == 0) begin
          n = 9'(nodes_used - 1);
          node_tab[n] = {1'b1, 10'b0, leaf_shift};
          if (stack_top == 0) begin
            if (n == 0) begin
              // single leaf: the whole text is this symbol
              ph = PH_HALT;
              add_expected(leaf_shift, 1'b1, 1'b1, 1'b0);
            end else begin
              ph      = PH_WALK;
              walk_at = '0;
            end
          end
        end
        return;
      end
      if (nodes_used >= NODE_CAP - 1) begin
        ph = PH_HALT;
        add_expected(8'h00, 1'b0, 1'b0, 1'b1);
        return;
      end
      n = 9'(nodes_used);
      if (n != 0 && stack_top != 0) begin
        stack_top--;
        slot = slot_stk[stack_top];
        if (slot[0]) node_tab[slot[9:1]][8:0]  = n;
        else         node_tab[slot[9:1]][17:9] = n;
      end
      nodes_used++;
      if (b) begin
        if (stack_top + 2 > STACK_CAP) begin
          ph = PH_HALT;
          add_expected(8'h00, 1'b0, 1'b0, 1'b1);
          return;
        end
        node_tab[n] = '0;
        slot_stk[stack_top] = {n, 1'b1};
        stack_top++;
        slot_stk[stack_top] = {n, 1'b0};
        stack_top++;
      end else begin
        leaf_left  = SYM_BITS;
        leaf_shift = '0;
      end
    endfunction

    function void walk_bit(bit b);
      logic [18:0] e;
      logic [18:0] ce;
      logic [8:0]  c;
      e  = node_tab[walk_at];
      c  = b ? e[8:0] : e[17:9];
      ce = node_tab[c];
      if (ce[18]) begin
        syms_left--;
        walk_at = '0;
        if (syms_left == 0) ph = PH_HALT;
        add_expected(ce[7:0], syms_left == 0, 1'b0, 1'b0);
      end else begin
        walk_at = c;
      end
    endfunction

    // one accepted code bit request
    function void note_bit(bit b, bit st);
      if (st) begin
        stack_top  = 0;
        nodes_used = 0;
        leaf_left  = 0;
        leaf_shift = '0;
        walk_at    = '0;
        syms_left  = count_reg;
        if (syms_left == 0) begin
          ph = PH_HALT;
          return;
        end
        ph = PH_TREE;
      end
      if (ph == PH_TREE)      load_tree_bit(b);
      else if (ph == PH_WALK) walk_bit(b);
    endfunction

    // one accepted symbol request against the oldest expectation
    function void check_symbol(result_t got);
      result_t want;
      if (expected_syms.size() == 0) begin
        if (fails < 10)
          $display("unexpected symbol %h last %b whole %b err %b",
                   got.symbol, got.last, got.whole_text, got.tree_error);
        fails++;
        return;
      end
      want = expected_syms.pop_front();
      if (got.symbol !== want.symbol || got.last !== want.last ||
          got.whole_text !== want.whole_text || got.tree_error !== want.tree_error) begin
        if (fails < 10)
          $display("mismatch: exp sym %h last %b whole %b err %b, got sym %h last %b whole %b err %b",
                   want.symbol, want.last, want.whole_text, want.tree_error,
                   got.symbol, got.last, got.whole_text, got.tree_error);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [0] code_bit, [7:1] zero
  logic [0:0]  s_axis_tuser = '0;   // [0] stream_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] symbol
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;        // [0] whole_text, [1] tree_error

  symbol_scoreboard sb;
  int unsigned idle_pct   = 0;     // chance of an idle burst per request, both sides
  int unsigned items_sent = 0;
  int unsigned quiet      = 0;
  int unsigned cut_at     = 0;     // truncates a tree after this many bits, zero for none
  int unsigned stream_bits = 0;
  bit          mark_start = 1'b0;
  int unsigned hold_left  = 0;

  huffman_bitstream_decoder #(
    .MAX_NODES  (NODE_CAP),
    .STACK_DEPTH(STACK_CAP),
    .SYMBOL_BITS(SYM_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // monitor of both channels plus the no-progress watchdog
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      // outputs first: a symbol never comes in the cycle its code bit enters
      if (m_axis_tvalid && m_axis_tready) begin
        got.symbol     = m_axis_tdata;
        got.last       = m_axis_tlast;
        got.whole_text = m_axis_tuser[0];
        got.tree_error = m_axis_tuser[1];
        sb.check_symbol(got);
      end
      if (s_axis_tvalid && s_axis_tready)
        sb.note_bit(s_axis_tdata[0], s_axis_tuser[0]);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // symbol side backpressure in short random bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) hold_left--;
      else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        hold_left = $urandom_range(1, 3);
      m_axis_tready <= (hold_left == 0) && rst_ni;
    end
  end

  // one code bit request, held until accepted
  task automatic send_req(bit b, bit st);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, b};
    s_axis_tuser  <= st;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic put(bit b);
    if (items_sent >= TAIL_FROM) idle_pct = 0;
    send_req(b, mark_start);
    mark_start = 1'b0;
    stream_bits++;
    items_sent++;
  endtask

  task automatic begin_stream();
    mark_start  = 1'b1;
    stream_bits = 0;
  endtask

  task automatic send_byte(logic [7:0] s);
    for (int i = 7; i >= 0; i--)
      if (cut_at == 0 || stream_bits < cut_at) put(s[i]);
  endtask

  // random preorder tree with at most max_leaves leaves
  task automatic send_tree(int unsigned max_leaves);
    int unsigned open_slots;
    int unsigned leaves_done;
    open_slots  = 1;
    leaves_done = 0;
    while (open_slots > 0 && (cut_at == 0 || stream_bits < cut_at)) begin
      if (leaves_done + open_slots < max_leaves && $urandom_range(0, 1) == 1) begin
        put(1'b1);
        open_slots++;
      end else begin
        put(1'b0);
        send_byte(8'($urandom_range(0, 255)));
        open_slots--;
        leaves_done++;
      end
    end
  endtask

  // stop sending and let every expected symbol arrive
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_count(logic [31:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_count(v);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd1;
      8:       return $urandom;
      9:       return $urandom_range(13, 60);
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  initial begin
    int unsigned kind;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bits before any stream are dropped
    put(1'b1);
    put(1'b0);
    // stream start with an empty text, then a dropped bit
    begin_stream();
    put(1'b1);
    put(1'b0);

    write_count(32'd2);
    // partial tree, abandoned by the next start
    begin_stream();
    put(1'b1);
    put(1'b0);
    put(1'b1);
    // single leaf tree
    begin_stream();
    put(1'b0);
    send_byte(8'hFF);
    put(1'b0);
    // two leaves, both walked, then a bit after the last symbol
    begin_stream();
    put(1'b1);
    put(1'b0);
    send_byte(8'h00);
    put(1'b0);
    send_byte(8'hFF);
    put(1'b0);
    put(1'b1);
    put(1'b1);

    // stack overflow: a long run of internal nodes
    idle_pct = 25;
    write_count($urandom_range(1, 50));
    begin_stream();
    repeat (257 + $urandom_range(0, 3)) put(1'b1);

    // node overflow: deep stack held near full while nodes pile up
    write_count(32'hFFFF_FFFF);
    begin_stream();
    repeat (255) put(1'b1);
    repeat (128) begin
      put(1'b0);
      send_byte(8'($urandom_range(0, 255)));
      put(1'b1);
    end
    repeat ($urandom_range(1, 4)) put(1'($urandom_range(0, 1)));

    items_sent = 0;
    while (items_sent < RAND_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        2:       idle_pct = 25;
        default: idle_pct = 40;
      endcase
      if (items_sent >= TAIL_FROM) idle_pct = 0;
      write_count(pick_count());
      repeat ($urandom_range(1, 4)) begin
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
          // well-formed tree followed by random code bits
          begin_stream();
          send_tree($urandom_range(2, 12));
          repeat ($urandom_range(4, 40)) put(1'($urandom_range(0, 1)));
        end else if (kind < 78) begin
          begin_stream();
          cut_at = $urandom_range(1, 30);
          send_tree($urandom_range(2, 12));
          cut_at = 0;
        end else if (kind < 88) begin
          begin_stream();
          send_tree(1);
          repeat ($urandom_range(0, 3)) put(1'($urandom_range(0, 1)));
        end else begin
          // bits with no stream start
          repeat ($urandom_range(1, 6)) put(1'($urandom_range(0, 1)));
        end
      end
    end

    drain();
    if (sb.fails == 0 && sb.pending() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
